### hw/rtl/ld3_pkg.sv
// Package for the 3D line distance block: widths, config register codes,
// payload structs and the flag bundle that runs through the root pipeline.
// No dependencies.
package ld3_pkg;

    localparam int COORD_BITS = 16;

    // Derived widths
    localparam int WW        = COORD_BITS + 1;       // query minus anchor
    localparam int CRW       = 2 * COORD_BITS + 2;   // cross product (P-A) x d
    localparam int NVW       = 2 * COORD_BITS + 1;   // direction cross d x e
    localparam int DOTW      = 3 * COORD_BITS + 4;   // (Q-A) . n
    localparam int NUMW      = 6 * COORD_BITS + 8;   // squared numerator
    localparam int DENW      = 4 * COORD_BITS + 4;   // squared denominator
    localparam int RB        = COORD_BITS + 1;       // root bits
    localparam int DISTW     = 17;
    localparam logic [DISTW-1:0] DIST_MAX = 17'h1FFFF;

    // Multiplier chunking and latency
    localparam int MUL_CHUNK = 17;
    localparam int MUL_LAT   = 5;

    // Config register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_LINE  = 1'b1;

    typedef struct packed {
        logic                          operation;
        logic signed [COORD_BITS-1:0]  query_x;
        logic signed [COORD_BITS-1:0]  query_y;
        logic signed [COORD_BITS-1:0]  query_z;
        logic signed [COORD_BITS-1:0]  query_dir_x;
        logic signed [COORD_BITS-1:0]  query_dir_y;
        logic signed [COORD_BITS-1:0]  query_dir_z;
    } t_in;

    typedef struct packed {
        logic [DISTW-1:0] distance;
        logic             on_line;
        logic             parallel;
        logic             degenerate;
    } t_out;

    typedef struct packed {
        logic v;
        logic onl;
        logic par;
        logic deg;
    } t_flags;

endpackage

### hw/rtl/ld3_mul.sv
// Pipelined signed multiplier built from chunk partial products.
// Five register stages: magnitude, partial products, row sums, total, sign.
// Depends on ld3_pkg.
module ld3_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic                     i_clk,
    input  logic                     i_ce,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);
    import ld3_pkg::*;

    localparam int CW = MUL_CHUNK;
    localparam int PW = AW + BW;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;

    logic [AW-1:0]      r_ma;
    logic [BW-1:0]      r_mb;
    logic [3:0]         r_neg;
    logic [2*CW-1:0]    r_pp [NA][NB];
    logic [PW-1:0]      r_row [NA];
    logic [PW-1:0]      n_row [NA];
    logic [PW-1:0]      r_mag;
    logic [PW-1:0]      n_mag;
    logic [PW-1:0]      r_p;
    logic [NA*CW-1:0]   a_ext;
    logic [NB*CW-1:0]   b_ext;

    assign a_ext = (NA*CW)'(r_ma);
    assign b_ext = (NB*CW)'(r_mb);

    always_comb begin
        logic [PW-1:0] acc;
        for (int i = 0; i < NA; i++) begin
            acc = '0;
            for (int j = 0; j < NB; j++) begin
                acc = acc + (PW'(r_pp[i][j]) << (CW * j));
            end
            n_row[i] = acc;
        end
    end

    always_comb begin
        n_mag = '0;
        for (int i = 0; i < NA; i++) begin
            n_mag = n_mag + (r_row[i] << (CW * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ma     <= i_a[AW-1] ? $unsigned(-i_a) : $unsigned(i_a);
            r_mb     <= i_b[BW-1] ? $unsigned(-i_b) : $unsigned(i_b);
            r_neg    <= {r_neg[2:0], i_a[AW-1] ^ i_b[BW-1]};
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= a_ext[i*CW +: CW] * b_ext[j*CW +: CW];
                end
                r_row[i] <= n_row[i];
            end
            r_mag    <= n_mag;
            r_p      <= r_neg[3] ? (~r_mag + PW'(1)) : r_mag;
        end
    end

    assign o_p = $signed(r_p);

endmodule

### hw/rtl/ld3_root.sv
// Bit-serial pipeline for the largest D with D*D*den <= num.
// One root bit per stage, residual and D*den kept so each stage is add/compare.
// Depends on ld3_pkg.
module ld3_root (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_ce,
    input  logic [ld3_pkg::NUMW-1:0] i_num,
    input  logic [ld3_pkg::DENW-1:0] i_den,
    input  ld3_pkg::t_flags         i_flags,
    output logic [ld3_pkg::RB-1:0]  o_root,
    output ld3_pkg::t_flags         o_flags
);
    import ld3_pkg::*;

    logic [NUMW-1:0] r_rem [RB+1];
    logic [NUMW-1:0] r_pd  [RB+1];
    logic [DENW-1:0] r_den [RB+1];
    logic [RB-1:0]   r_rt  [RB+1];
    t_flags          r_fl  [RB+1];

    logic [NUMW-1:0] n_rem   [RB];
    logic [NUMW-1:0] n_pd    [RB];
    logic [RB-1:0]   n_rt    [RB];
    logic [NUMW-1:0] n_trial [RB];

    always_comb begin
        int b;
        for (int s = 0; s < RB; s++) begin
            b = RB - 1 - s;
            // (c^2 - d^2) * den with c = d + 2^b
            n_trial[s] = (r_pd[s] << (b + 1)) + (NUMW'(r_den[s]) << (2 * b));
            if (n_trial[s] <= r_rem[s]) begin
                n_rem[s] = r_rem[s] - n_trial[s];
                n_pd[s]  = r_pd[s] + (NUMW'(r_den[s]) << b);
                n_rt[s]  = r_rt[s] | (RB'(1) << b);
            end else begin
                n_rem[s] = r_rem[s];
                n_pd[s]  = r_pd[s];
                n_rt[s]  = r_rt[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= RB; s++) begin
                r_fl[s] <= '0;
            end
        end else if (i_ce) begin
            r_fl[0] <= i_flags;
            for (int s = 0; s < RB; s++) begin
                r_fl[s+1] <= r_fl[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= i_num;
            r_pd[0]  <= '0;
            r_den[0] <= i_den;
            r_rt[0]  <= '0;
            for (int s = 0; s < RB; s++) begin
                r_rem[s+1] <= n_rem[s];
                r_pd[s+1]  <= n_pd[s];
                r_den[s+1] <= r_den[s];
                r_rt[s+1]  <= n_rt[s];
            end
        end
    end

    assign o_root  = r_rt[RB];
    assign o_flags = r_fl[RB];

endmodule

### hw/rtl/line_distance_3d.sv
// Top level of the 3D line distance block.
// Depends on ld3_pkg, ld3_mul and ld3_root.
//
// Usage:
//  - Config port: write anchor and direction of the stored line through
//    i_cfg_we / i_cfg_index / i_cfg_data while no transfer is in flight.
//    Reset clears all six registers to zero.
//  - Input channel (i_in_valid / o_in_stall / i_in_data): one query per
//    transfer. Operation 0 is point-to-line, operation 1 is line-to-line.
//  - Output channel (o_out_valid / i_out_stall / o_out_data): one result per
//    query, in order.
//  - Pipeline from input transfer to o_out_valid: input register, three
//    multiplier layers (sum register after the first two), the 18-register
//    root pipeline (17 root bits) and the output register.
//  - Throughput: one transfer per cycle while o_in_stall is low.
//  - Stall: the whole pipeline holds while a result sits in the output
//    register and the receiver stalls; o_in_stall is asserted then.
//  - Reset clears all valid bits; nothing in flight survives.
module line_distance_3d (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ld3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ld3_pkg::COORD_BITS-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  ld3_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ld3_pkg::t_out                      o_out_data
);
    import ld3_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int XW = RB + DISTW;

    // side data riding alongside the multiplier layers
    typedef struct packed {
        logic               v;
        logic               op;
        logic [2:0][WW-1:0] w;
    } t_side1;

    typedef struct packed {
        logic            v;
        logic            op;
        logic            onl;
        logic            par;
        logic [DENW-1:0] dend;
    } t_side2;

    typedef struct packed {
        logic            v;
        logic            op;
        logic            onl;
        logic            par;
        logic [DENW-1:0] dend;
        logic [NUMW-1:0] nump;
        logic [DENW-1:0] denn;
    } t_side3;

    logic ce;

    // config
    logic signed [C-1:0] r_anc [3];
    logic signed [C-1:0] r_dir [3];

    // stage 1: w = q - A
    logic                 r1_v;
    logic                 r1_op;
    logic signed [WW-1:0] r1_w [3];
    logic signed [C-1:0]  r1_e [3];
    logic signed [C-1:0]  q [3];
    logic signed [C-1:0]  e [3];

    // layer 1
    logic signed [WW+C-1:0] m1_c [3][2];
    logic signed [2*C-1:0]  m1_n [3][2];
    logic signed [2*C-1:0]  m1_d [3];
    t_side1                 r_dl1 [MUL_LAT];
    t_side1                 s1_in;
    t_side1                 s1_out;

    // stage 2
    logic signed [CRW-1:0] n_c [3];
    logic signed [NVW-1:0] n_n [3];
    logic                  r2_v;
    logic                  r2_op;
    logic                  r2_onl;
    logic                  r2_par;
    logic [DENW-1:0]       r2_dend;
    logic signed [WW-1:0]  r2_w [3];
    logic signed [CRW-1:0] r2_c [3];
    logic signed [NVW-1:0] r2_n [3];

    // layer 2
    logic signed [2*CRW-1:0]  m2_cc [3];
    logic signed [2*NVW-1:0]  m2_nn [3];
    logic signed [WW+NVW-1:0] m2_wn [3];
    t_side2                   r_dl2 [MUL_LAT];
    t_side2                   s2_in;
    t_side2                   s2_out;

    // stage 3
    logic                   r3_v;
    logic                   r3_op;
    logic                   r3_onl;
    logic                   r3_par;
    logic [DENW-1:0]        r3_dend;
    logic [NUMW-1:0]        r3_nump;
    logic [DENW-1:0]        r3_denn;
    logic signed [DOTW-1:0] r3_dot;

    // layer 3
    logic signed [2*DOTW-1:0] m3_dd;
    t_side3                   r_dl3 [MUL_LAT];
    t_side3                   s3_in;
    t_side3                   s3_out;

    // root
    logic [NUMW-1:0] rt_num;
    logic [DENW-1:0] rt_den;
    t_flags          rt_fl_in;
    logic [RB-1:0]   rt_root;
    t_flags          rt_fl_out;

    // output
    logic             r_out_valid;
    t_out             r_out;
    logic [DISTW-1:0] n_dist;

    // pipeline moves unless a finished result is blocked
    assign ce         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_anc[k] <= '0;
                r_dir[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ANCHOR_X: r_anc[0] <= i_cfg_data;
                CFG_ANCHOR_Y: r_anc[1] <= i_cfg_data;
                CFG_ANCHOR_Z: r_anc[2] <= i_cfg_data;
                CFG_DIR_X:    r_dir[0] <= i_cfg_data;
                CFG_DIR_Y:    r_dir[1] <= i_cfg_data;
                CFG_DIR_Z:    r_dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1 ----------------
    always_comb begin
        q[0] = i_in_data.query_x;
        q[1] = i_in_data.query_y;
        q[2] = i_in_data.query_z;
        e[0] = i_in_data.query_dir_x;
        e[1] = i_in_data.query_dir_y;
        e[2] = i_in_data.query_dir_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (ce) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_op <= i_in_data.operation;
            for (int k = 0; k < 3; k++) begin
                r1_w[k] <= WW'(q[k]) - WW'(r_anc[k]);
                r1_e[k] <= e[k];
            end
        end
    end

    // ---------------- layer 1: cross terms and |d|^2 ----------------
    for (genvar k = 0; k < 3; k++) begin : g_l1
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        ld3_mul #(.AW(WW), .BW(C)) u_c0 (
            .i_clk(i_clk), .i_ce(ce), .i_a(r1_w[K1]), .i_b(r_dir[K2]), .o_p(m1_c[k][0])
        );
        ld3_mul #(.AW(WW), .BW(C)) u_c1 (
            .i_clk(i_clk), .i_ce(ce), .i_a(r1_w[K2]), .i_b(r_dir[K1]), .o_p(m1_c[k][1])
        );
        ld3_mul #(.AW(C), .BW(C)) u_n0 (
            .i_clk(i_clk), .i_ce(ce), .i_a(r_dir[K1]), .i_b(r1_e[K2]), .o_p(m1_n[k][0])
        );
        ld3_mul #(.AW(C), .BW(C)) u_n1 (
            .i_clk(i_clk), .i_ce(ce), .i_a(r_dir[K2]), .i_b(r1_e[K1]), .o_p(m1_n[k][1])
        );
        ld3_mul #(.AW(C), .BW(C)) u_d (
            .i_clk(i_clk), .i_ce(ce), .i_a(r_dir[k]), .i_b(r_dir[k]), .o_p(m1_d[k])
        );
    end

    always_comb begin
        s1_in.v  = r1_v;
        s1_in.op = r1_op;
        for (int k = 0; k < 3; k++) begin
            s1_in.w[k] = r1_w[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MUL_LAT; i++) begin
                r_dl1[i] <= '0;
            end
        end else if (ce) begin
            r_dl1[0] <= s1_in;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_dl1[i] <= r_dl1[i-1];
            end
        end
    end

    assign s1_out = r_dl1[MUL_LAT-1];

    // ---------------- stage 2: c = w x d, n = d x e ----------------
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_c[k] = CRW'(m1_c[k][0]) - CRW'(m1_c[k][1]);
            n_n[k] = NVW'(m1_n[k][0]) - NVW'(m1_n[k][1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (ce) begin
            r2_v <= s1_out.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r2_op   <= s1_out.op;
            r2_dend <= DENW'(m1_d[0]) + DENW'(m1_d[1]) + DENW'(m1_d[2]);
            r2_onl  <= (n_c[0] == '0) && (n_c[1] == '0) && (n_c[2] == '0);
            r2_par  <= (n_n[0] == '0) && (n_n[1] == '0) && (n_n[2] == '0);
            for (int k = 0; k < 3; k++) begin
                r2_w[k] <= $signed(s1_out.w[k]);
                r2_c[k] <= n_c[k];
                r2_n[k] <= n_n[k];
            end
        end
    end

    // ---------------- layer 2: squares and w . n terms ----------------
    for (genvar k = 0; k < 3; k++) begin : g_l2
        ld3_mul #(.AW(CRW), .BW(CRW)) u_cc (
            .i_clk(i_clk), .i_ce(ce), .i_a(r2_c[k]), .i_b(r2_c[k]), .o_p(m2_cc[k])
        );
        ld3_mul #(.AW(NVW), .BW(NVW)) u_nn (
            .i_clk(i_clk), .i_ce(ce), .i_a(r2_n[k]), .i_b(r2_n[k]), .o_p(m2_nn[k])
        );
        ld3_mul #(.AW(WW), .BW(NVW)) u_wn (
            .i_clk(i_clk), .i_ce(ce), .i_a(r2_w[k]), .i_b(r2_n[k]), .o_p(m2_wn[k])
        );
    end

    always_comb begin
        s2_in.v    = r2_v;
        s2_in.op   = r2_op;
        s2_in.onl  = r2_onl;
        s2_in.par  = r2_par;
        s2_in.dend = r2_dend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MUL_LAT; i++) begin
                r_dl2[i] <= '0;
            end
        end else if (ce) begin
            r_dl2[0] <= s2_in;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_dl2[i] <= r_dl2[i-1];
            end
        end
    end

    assign s2_out = r_dl2[MUL_LAT-1];

    // ---------------- stage 3: sums ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (ce) begin
            r3_v <= s2_out.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r3_op   <= s2_out.op;
            r3_onl  <= s2_out.onl;
            r3_par  <= s2_out.par;
            r3_dend <= s2_out.dend;
            r3_nump <= NUMW'(m2_cc[0]) + NUMW'(m2_cc[1]) + NUMW'(m2_cc[2]);
            r3_denn <= DENW'(m2_nn[0]) + DENW'(m2_nn[1]) + DENW'(m2_nn[2]);
            r3_dot  <= DOTW'(m2_wn[0]) + DOTW'(m2_wn[1]) + DOTW'(m2_wn[2]);
        end
    end

    // ---------------- layer 3: dot^2 ----------------
    ld3_mul #(.AW(DOTW), .BW(DOTW)) u_dd (
        .i_clk(i_clk), .i_ce(ce), .i_a(r3_dot), .i_b(r3_dot), .o_p(m3_dd)
    );

    always_comb begin
        s3_in.v    = r3_v;
        s3_in.op   = r3_op;
        s3_in.onl  = r3_onl;
        s3_in.par  = r3_par;
        s3_in.dend = r3_dend;
        s3_in.nump = r3_nump;
        s3_in.denn = r3_denn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MUL_LAT; i++) begin
                r_dl3[i] <= '0;
            end
        end else if (ce) begin
            r_dl3[0] <= s3_in;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_dl3[i] <= r_dl3[i-1];
            end
        end
    end

    assign s3_out = r_dl3[MUL_LAT-1];

    // ---------------- select ratio for the root ----------------
    // point query and parallel lines both use |w x d|^2 / |d|^2
    always_comb begin
        rt_fl_in.v = s3_out.v;
        if (s3_out.op == OP_POINT) begin
            rt_num       = s3_out.nump;
            rt_den       = s3_out.dend;
            rt_fl_in.onl = s3_out.onl;
            rt_fl_in.par = 1'b0;
        end else if (s3_out.par) begin
            rt_num       = s3_out.nump;
            rt_den       = s3_out.dend;
            rt_fl_in.onl = 1'b0;
            rt_fl_in.par = 1'b1;
        end else begin
            rt_num       = $unsigned(m3_dd);
            rt_den       = s3_out.denn;
            rt_fl_in.onl = 1'b0;
            rt_fl_in.par = 1'b0;
        end
        rt_fl_in.deg = (rt_den == '0);
    end

    ld3_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_num   (rt_num),
        .i_den   (rt_den),
        .i_flags (rt_fl_in),
        .o_root  (rt_root),
        .o_flags (rt_fl_out)
    );

    // ---------------- output register ----------------
    always_comb begin
        if (rt_fl_out.deg) begin
            n_dist = '0;
        end else if (XW'(rt_root) > XW'(DIST_MAX)) begin
            n_dist = DIST_MAX;
        end else begin
            n_dist = DISTW'(rt_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= rt_fl_out.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out.distance   <= n_dist;
            r_out.on_line    <= rt_fl_out.onl;
            r_out.parallel   <= rt_fl_out.par;
            r_out.degenerate <= rt_fl_out.deg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### verif/tb_line_distance_3d.sv
// Self-checking testbench for line_distance_3d: point-to-line and line-to-line
// distance queries against an exact integer predictor, under random stalls.
// Depends on ld3_pkg and the line_distance_3d RTL.
`timescale 1ns / 1ps

module tb_line_distance_3d;
    import ld3_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [COORD_BITS-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in                    i_in_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out                   o_out_data;

    line_distance_3d u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Stored line as the predictor sees it
    longint line_ax, line_ay, line_az, line_dx, line_dy, line_dz;

    t_in    query_q[$];         // queries waiting to be driven
    t_out   dist_expected[$];   // predicted results, oldest first
    int     send_idle_pct;
    int     recv_idle_pct;
    int     n_errors;
    int     n_queries;
    int     n_results;

    function automatic logic [255:0] square(longint v);
        logic signed [255:0] w;
        w = v;
        return w * w;
    endfunction

    // Largest D with D*D*den <= num; zero den flags degenerate.
    function automatic logic [DISTW-1:0] root_ratio(logic [255:0] num, logic [255:0] den,
                                                  output logic deg);
        logic [255:0] d;
        logic [255:0] c;
        d = '0;
        deg = (den == 0);
        if (deg) return '0;
        for (int b = COORD_BITS; b >= 0; b--) begin
            c = d | (256'd1 << b);
            if (c * c * den <= num) d = c;
        end
        return (d > 256'd131071) ? DIST_MAX : d[DISTW-1:0];
    endfunction

    function automatic logic [DISTW-1:0] point_distance(longint px, longint py, longint pz,
                                                       output logic onl, output logic deg);
        longint wx, wy, wz, cx, cy, cz;
        wx = px - line_ax; wy = py - line_ay; wz = pz - line_az;
        cx = wy * line_dz - wz * line_dy;
        cy = wz * line_dx - wx * line_dz;
        cz = wx * line_dy - wy * line_dx;
        onl = (cx == 0 && cy == 0 && cz == 0);
        return root_ratio(square(cx) + square(cy) + square(cz),
                          square(line_dx) + square(line_dy) + square(line_dz), deg);
    endfunction

    function automatic t_out predict_distance(t_in q);
        t_out   r;
        longint qx, qy, qz, ex, ey, ez, nx, ny, nz, dot;
        logic   onl, deg;
        qx = q.query_x; qy = q.query_y; qz = q.query_z;
        ex = q.query_dir_x; ey = q.query_dir_y; ez = q.query_dir_z;
        r = '0;
        if (q.operation == OP_POINT) begin
            r.distance = point_distance(qx, qy, qz, onl, deg);
            r.on_line = onl;
            r.degenerate = deg;
        end else begin
            nx = line_dy * ez - line_dz * ey;
            ny = line_dz * ex - line_dx * ez;
            nz = line_dx * ey - line_dy * ex;
            if (nx == 0 && ny == 0 && nz == 0) begin
                // parallel lines: fall back to distance of the query anchor
                r.distance = point_distance(qx, qy, qz, onl, deg);
                r.parallel = 1'b1;
            end else begin
                dot = (qx - line_ax) * nx + (qy - line_ay) * ny + (qz - line_az) * nz;
                r.distance = root_ratio(square(dot),
                                        square(nx) + square(ny) + square(nz), deg);
            end
            r.degenerate = deg;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
        n_errors++;
    endtask

    // Driver: one transfer per accepted query; prediction taken at acceptance,
    // when the stored line is stable.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                dist_expected.push_back(predict_distance(i_in_data));
                n_queries++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (query_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= query_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random receiver stall, field-by-field compare
    always @(posedge i_clk) begin
        t_out want;
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (dist_expected.size() == 0) begin
                report_mismatch("arrived with nothing expected, distance",
                                o_out_data.distance, 0);
            end else begin
                want = dist_expected.pop_front();
                if (o_out_data.distance !== want.distance)
                    report_mismatch("distance", o_out_data.distance, want.distance);
                if (o_out_data.on_line !== want.on_line)
                    report_mismatch("on_line", o_out_data.on_line, want.on_line);
                if (o_out_data.parallel !== want.parallel)
                    report_mismatch("parallel", o_out_data.parallel, want.parallel);
                if (o_out_data.degenerate !== want.degenerate)
                    report_mismatch("degenerate", o_out_data.degenerate, want.degenerate);
            end
            n_results++;
        end
    end

    task automatic write_line(int ax, int ay, int az, int dx, int dy, int dz);
        int vals[6];
        logic signed [COORD_BITS-1:0] v;
        vals = '{ax, ay, az, dx, dy, dz};
        for (int i = 0; i < 6; i++) begin
            @(posedge i_clk);
            v = COORD_BITS'(vals[i]);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= v;
            case (i)
                CFG_ANCHOR_X: line_ax = v;
                CFG_ANCHOR_Y: line_ay = v;
                CFG_ANCHOR_Z: line_az = v;
                CFG_DIR_X:    line_dx = v;
                CFG_DIR_Y:    line_dy = v;
                default:      line_dz = v;
            endcase
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every query has left and every result has come, then let the
    // pipeline empty fully.
    task automatic drain;
        do begin
            @(posedge i_clk); #1;
        end while (query_q.size() > 0 || i_in_valid || dist_expected.size() > 0);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic add_query(logic op, int x, int y, int z, int ex, int ey, int ez);
        t_in q;
        q.operation = op;
        q.query_x = COORD_BITS'(x); q.query_y = COORD_BITS'(y); q.query_z = COORD_BITS'(z);
        q.query_dir_x = COORD_BITS'(ex);
        q.query_dir_y = COORD_BITS'(ey);
        q.query_dir_z = COORD_BITS'(ez);
        query_q.push_back(q);
    endtask

    function automatic int rnd_coord();
        case ($urandom_range(3))
            0:       return $urandom_range(65535) - 32768;
            1:       return $urandom_range(64) - 32;
            2:       return $urandom_range(1) ? 32767 : -32768;
            default: return $urandom_range(4095) - 2048;
        endcase
    endfunction

    task automatic add_random_query;
        int k;
        k = $urandom_range(7) - 3;
        case ($urandom_range(4))
            0: // query point on the stored line
                add_query(OP_POINT, int'(line_ax + k * line_dx), int'(line_ay + k * line_dy),
                          int'(line_az + k * line_dz), rnd_coord(), rnd_coord(), rnd_coord());
            1: // query line parallel to the stored line
                add_query(OP_LINE, rnd_coord(), rnd_coord(), rnd_coord(),
                          int'(k * line_dx), int'(k * line_dy), int'(k * line_dz));
            default:
                add_query(1'($urandom_range(1)), rnd_coord(), rnd_coord(), rnd_coord(),
                          rnd_coord(), rnd_coord(), rnd_coord());
        endcase
    endtask

    task automatic random_phase(int n);
        int dx, dy, dz;
        dx = $urandom_range(1) ? rnd_coord() : $urandom_range(40) - 20;
        dy = $urandom_range(1) ? rnd_coord() : $urandom_range(40) - 20;
        dz = $urandom_range(1) ? rnd_coord() : $urandom_range(40) - 20;
        write_line(rnd_coord(), rnd_coord(), rnd_coord(), dx, dy, dz);
        for (int i = 0; i < n / 2; i++) add_random_query();
        // sender holds off here until every result is back
        drain();
        for (int i = 0; i < n - n / 2; i++) add_random_query();
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        n_errors = 0; n_queries = 0; n_results = 0;
        line_ax = 0; line_ay = 0; line_az = 0;
        line_dx = 0; line_dy = 0; line_dz = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero stored direction after reset: degenerate for both operations
        add_query(OP_POINT, 16, -16, 32767, 0, 0, 0);
        add_query(OP_LINE, -32768, 5, 7, 16, 0, 0);
        add_query(OP_LINE, 0, 0, 0, 0, 0, 0);
        drain();

        // Simple line along x
        write_line(0, 0, 0, 16, 0, 0);
        add_query(OP_POINT, 160, 0, 0, 0, 0, 0);             // on the line
        add_query(OP_POINT, 160, 48, 64, 0, 0, 0);           // off the line
        add_query(OP_POINT, 160, 48, 64, 32767, -32768, 1);  // direction is ignored
        add_query(OP_POINT, 32767, 32767, 32767, 0, 0, 0);
        add_query(OP_POINT, -32768, -32768, -32768, -1, -1, -1);
        add_query(OP_LINE, 0, 32, 0, 32, 0, 0);              // parallel
        add_query(OP_LINE, 5, 0, 0, -16, 0, 0);              // parallel and coincident
        add_query(OP_LINE, 0, 0, 0, 0, 0, 0);                // zero query direction
        add_query(OP_LINE, 0, 0, 80, 0, 16, 0);              // skew, 80 apart
        add_query(OP_LINE, 0, 0, 0, 0, 16, 0);               // intersecting
        add_query(OP_LINE, 32767, -32768, 32767, -32768, 32767, -32768);
        drain();

        // Extreme line registers
        write_line(-32768, 32767, -32768, 32767, -32768, 32767);
        add_query(OP_POINT, 32767, -32768, 32767, 0, 0, 0);
        add_query(OP_POINT, -32768, 32767, -32768, 0, 0, 0);
        add_query(OP_LINE, 32767, -32768, 32767, -32768, -32768, -32768);
        add_query(OP_LINE, 32767, 32767, 32767, -32767, 32768, -32767);
        add_query(OP_LINE, -32768, -32768, 32767, 32767, 32767, -32768);
        add_query(OP_POINT, 0, 0, 0, 0, 0, 0);
        drain();

        send_idle_pct = 21; recv_idle_pct = 69;
        random_phase(90);
        random_phase(80);
        send_idle_pct = 69; recv_idle_pct = 21;
        random_phase(90);
        random_phase(80);
        send_idle_pct = 0;  recv_idle_pct = 0;
        random_phase(90);
        random_phase(80);

        $display("Covered %0d queries and %0d results over directed and random lines,",
                 n_queries, n_results);
        $display("with sender and receiver stalls in both balances and back to back.");
        if (n_errors == 0 && dist_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding", dist_expected.size());
        $display("Verification failed");
        $finish;
    end

endmodule
